// ===== design/cqes_pkg.sv =====
// Shared constants, codes and types of the calendar-queue event scheduler.
package cqes_pkg;

   localparam int NUM_EVENTS    = 1024;
   localparam int ID_BITS       = $clog2(NUM_EVENTS);
   localparam int LINK_BITS     = ID_BITS + 1;
   localparam int NUM_BINS      = 256;
   localparam int BIN_BITS      = $clog2(NUM_BINS);
   localparam int TIME_BITS     = 32;
   localparam int TSH_BITS      = $clog2(TIME_BITS);
   localparam int SHAMT_BITS    = TSH_BITS + 1;
   localparam int SHIFT_BITS    = 5;
   localparam int CNT_BITS      = ID_BITS + 1;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [LINK_BITS-1:0]    NOT_PENDING     = LINK_BITS'(NUM_EVENTS);
   localparam logic [SHIFT_BITS-1:0]   BIN_SHIFT_RESET = SHIFT_BITS'(4);
   localparam logic [TIME_BITS-1:0]    START_RESET     = '0;

   localparam logic [CSR_IDX_BITS-1:0] CSR_START_TIME  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIN_SHIFT   = CSR_IDX_BITS'(1);

   typedef enum logic [1:0] {
      MODE_SCHED  = 2'd0,
      MODE_CANCEL = 2'd1,
      MODE_NEXT   = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_BAD_ID   = 3'd1,
      STS_ALREADY  = 3'd2,
      STS_NOT_SCHED = 3'd3,
      STS_PAST     = 3'd4,
      STS_EMPTY    = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCHED,
      S_CAN_LOOK,
      S_CAN_HEAD,
      S_CAN_WALK,
      S_CAN_FIX,
      S_NXT_HEAD,
      S_NXT_EVAL,
      S_NXT_FIX,
      S_NXT_FREE,
      S_DONE
   } state_type;

endpackage

// ===== design/cqes_window.sv =====
// Calendar window and bin index of a time relative to the cycle origin.
module cqes_window (
   input  logic [cqes_pkg::TIME_BITS-1:0]  evt_time,
   input  logic [cqes_pkg::TIME_BITS-1:0]  cyc_origin,
   input  logic [cqes_pkg::SHIFT_BITS-1:0] bin_shift,
   output logic [cqes_pkg::TIME_BITS-1:0]  win,
   output logic [cqes_pkg::BIN_BITS-1:0]   bin
);
   import cqes_pkg::*;

   logic [TIME_BITS-1:0] rel;

   assign rel = evt_time - cyc_origin;
   assign win = rel >> bin_shift;
   assign bin = win[BIN_BITS-1:0];

endmodule

// ===== design/calendar_queue_event_scheduler_core.sv =====
// Calendar-queue event scheduler: schedule, cancel and take-next over linked bin lists.
// After reset the block clears its link and bin-head memories and accepts no
// item during that pass (configuration writes wait as well). Each item then steps
// through states paced by the registered reads of the link, due-time and bin-head
// memories: schedule links the event in at its bin head, cancel walks each list entry
// ahead of the event, and next visits each bin in turn and each event in it. Next walks
// bins from the current one, taking only events in the 256 windows that start at the
// current window; if that sweep finds nothing it sweeps all bins again without the
// window, so a sparse far-future queue is walked twice. Results leave through an
// output register, so a stalled result holds up only the next item's finish.
module calendar_queue_event_scheduler_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [cqes_pkg::ID_BITS-1:0]        req_event_id,
   input  logic [cqes_pkg::TIME_BITS-1:0]      req_event_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cqes_pkg::ID_BITS-1:0]        rsp_next_id,
   output logic [cqes_pkg::TIME_BITS-1:0]      rsp_next_time,
   output logic [2:0]                          rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cqes_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [cqes_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import cqes_pkg::*;

   // memories
   logic [TIME_BITS-1:0] due_mem  [NUM_EVENTS];
   logic [LINK_BITS-1:0] link_mem [NUM_EVENTS];
   logic [ID_BITS-1:0]   head_mem [NUM_BINS];

   logic                 due_we, link_we, head_we;
   logic [ID_BITS-1:0]   due_wa, due_ra, link_wa, link_ra;
   logic [BIN_BITS-1:0]  head_wa, head_ra;
   logic [TIME_BITS-1:0] due_wd;
   logic [LINK_BITS-1:0] link_wd;
   logic [ID_BITS-1:0]   head_wd;
   logic [TIME_BITS-1:0] due_rd_ff;
   logic [LINK_BITS-1:0] link_rd_ff;
   logic [ID_BITS-1:0]   head_rd_ff;

   state_type state_ff, state_in;

   logic [ID_BITS-1:0]    clr_ff, clr_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [BIN_BITS-1:0]   bin_ff, bin_in;
   logic [ID_BITS-1:0]    idnext_ff, idnext_in;
   logic [ID_BITS-1:0]    prev_ff, prev_in;
   logic [ID_BITS-1:0]    cur_ff, cur_in;
   logic [BIN_BITS-1:0]   i_ff, i_in;
   logic                  fall_ff, fall_in;
   logic [ID_BITS-1:0]    best_ff, best_in;
   logic [TIME_BITS-1:0]  best_t_ff, best_t_in;
   logic [ID_BITS-1:0]    best_prev_ff, best_prev_in;
   logic [BIN_BITS-1:0]   best_bin_ff, best_bin_in;
   logic [ID_BITS-1:0]    best_next_ff, best_next_in;
   logic [TIME_BITS-1:0]  win_base_ff, win_base_in;
   logic [CNT_BITS-1:0]   pend_cnt_ff, pend_cnt_in;
   logic [TIME_BITS-1:0]  cyc_origin_ff, cyc_origin_in;
   logic [TIME_BITS-1:0]  cur_time_ff, cur_time_in;
   logic [BIN_BITS-1:0]   cur_bin_ff, cur_bin_in;
   logic [TIME_BITS-1:0]  start_time_ff, start_time_in;
   logic [SHIFT_BITS-1:0] bin_shift_ff, bin_shift_in;
   logic [ID_BITS-1:0]    res_id_ff, res_id_in;
   logic [TIME_BITS-1:0]  res_time_ff, res_time_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]    rsp_next_id_ff, rsp_next_id_in;
   logic [TIME_BITS-1:0]  rsp_next_time_ff, rsp_next_time_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;

   logic [TIME_BITS-1:0]  req_win, rd_win, cur_win;
   logic [BIN_BITS-1:0]   req_bin, rd_bin, cur_bin_chk;
   logic                  acc, rsp_load;
   logic [ID_BITS-1:0]    can_cur, nx_ptr;
   logic                  last_bin, in_win, upd, found, list_end, to_fix, bin_adv;
   logic [BIN_BITS-1:0]   bin_cur, adv_addr;
   logic [TIME_BITS-1:0]  diff;
   logic [SHAMT_BITS-1:0] shamt;
   mode_type              req_mode_t;

   cqes_window u_win_req (
      .evt_time   (req_event_time),
      .cyc_origin (cyc_origin_ff),
      .bin_shift  (bin_shift_ff),
      .win        (req_win),
      .bin        (req_bin)
   );

   cqes_window u_win_rd (
      .evt_time   (due_rd_ff),
      .cyc_origin (cyc_origin_ff),
      .bin_shift  (bin_shift_ff),
      .win        (rd_win),
      .bin        (rd_bin)
   );

   cqes_window u_win_cur (
      .evt_time   (cur_time_ff),
      .cyc_origin (cyc_origin_ff),
      .bin_shift  (bin_shift_ff),
      .win        (cur_win),
      .bin        (cur_bin_chk)
   );

   always_ff @(posedge clock) begin
      if (due_we) begin
         due_mem[due_wa] <= due_wd;
      end
      due_rd_ff <= due_mem[due_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_rd_ff <= head_mem[head_ra];
   end

   assign req_mode_t = mode_type'(req_mode);
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign acc        = req_valid && !req_stall;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign can_cur  = (state_ff == S_CAN_HEAD) ? head_rd_ff : link_rd_ff[ID_BITS-1:0];
   assign nx_ptr   = link_rd_ff[ID_BITS-1:0];
   assign last_bin = (i_ff == BIN_BITS'(NUM_BINS - 1));
   assign bin_cur  = fall_ff ? i_ff : cur_bin_ff + i_ff;
   assign adv_addr = bin_cur + BIN_BITS'(1);
   assign in_win   = fall_ff ||
                     ({1'b0, rd_win} == ({1'b0, win_base_ff} + (TIME_BITS+1)'(i_ff)));
   assign upd      = (state_ff == S_NXT_EVAL) && in_win &&
                     ((best_ff == '0) || (due_rd_ff < best_t_ff));
   assign found    = upd || (best_ff != '0);
   assign list_end = ((state_ff == S_NXT_EVAL) && (nx_ptr == '0)) ||
                     ((state_ff == S_NXT_HEAD) && (head_rd_ff == '0));
   assign to_fix   = list_end && found && (!fall_ff || last_bin);
   assign bin_adv  = list_end && !to_fix;

   assign diff  = best_t_ff - cyc_origin_ff;
   assign shamt = SHAMT_BITS'(BIN_BITS) + SHAMT_BITS'(bin_shift_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ID_BITS'(NUM_EVENTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (acc) begin
               case (req_mode_t)
                  MODE_SCHED:  state_in = (req_event_id == '0) ? S_DONE : S_SCHED;
                  MODE_CANCEL: state_in = (req_event_id == '0) ? S_DONE : S_CAN_LOOK;
                  MODE_NEXT:   state_in = (pend_cnt_ff == '0) ? S_DONE : S_NXT_HEAD;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_SCHED: state_in = S_DONE;
         S_CAN_LOOK: begin
            state_in = (link_rd_ff == NOT_PENDING) ? S_DONE : S_CAN_HEAD;
         end
         S_CAN_HEAD, S_CAN_WALK: begin
            if (can_cur == '0) state_in = S_DONE;
            else if (can_cur == id_ff) state_in = S_CAN_FIX;
            else state_in = S_CAN_WALK;
         end
         S_CAN_FIX: state_in = S_DONE;
         S_NXT_HEAD, S_NXT_EVAL: begin
            if (to_fix) state_in = S_NXT_FIX;
            else if (bin_adv) state_in = (last_bin && fall_ff) ? S_DONE : S_NXT_HEAD;
            else state_in = S_NXT_EVAL;
         end
         S_NXT_FIX:  state_in = S_NXT_FREE;
         S_NXT_FREE: state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      due_we  = 1'b0;
      due_wa  = id_ff;
      due_wd  = time_ff;
      due_ra  = id_ff;
      link_we = 1'b0;
      link_wa = id_ff;
      link_wd = NOT_PENDING;
      link_ra = id_ff;
      head_we = 1'b0;
      head_wa = bin_ff;
      head_wd = '0;
      head_ra = bin_ff;

      clr_in        = clr_ff;
      id_in         = id_ff;
      time_in       = time_ff;
      bin_in        = bin_ff;
      idnext_in     = idnext_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      i_in          = i_ff;
      fall_in       = fall_ff;
      best_in       = best_ff;
      best_t_in     = best_t_ff;
      best_prev_in  = best_prev_ff;
      best_bin_in   = best_bin_ff;
      best_next_in  = best_next_ff;
      win_base_in   = win_base_ff;
      pend_cnt_in   = pend_cnt_ff;
      cyc_origin_in = cyc_origin_ff;
      cur_time_in   = cur_time_ff;
      cur_bin_in    = cur_bin_ff;
      start_time_in = start_time_ff;
      bin_shift_in  = bin_shift_ff;
      res_id_in     = res_id_ff;
      res_time_in   = res_time_ff;
      res_status_in = res_status_ff;

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_next_id_in   = rsp_next_id_ff;
      rsp_next_time_in = rsp_next_time_ff;
      rsp_status_in    = rsp_status_ff;

      case (state_ff)
         S_CLEAR: begin
            link_we = 1'b1;
            link_wa = clr_ff;
            head_we = 1'b1;
            head_wa = clr_ff[BIN_BITS-1:0];
            clr_in  = clr_ff + ID_BITS'(1);
         end
         S_IDLE: begin
            if (csr_valid && csr_ready && (pend_cnt_ff == '0)) begin
               case (csr_index)
                  CSR_START_TIME: begin
                     start_time_in = csr_data[TIME_BITS-1:0];
                     cyc_origin_in = csr_data[TIME_BITS-1:0];
                     cur_time_in   = csr_data[TIME_BITS-1:0];
                     cur_bin_in    = '0;
                  end
                  CSR_BIN_SHIFT: begin
                     // empty queue: rebase the calendar on the current time
                     bin_shift_in  = csr_data[SHIFT_BITS-1:0];
                     cyc_origin_in = cur_time_ff;
                     cur_bin_in    = '0;
                  end
                  default: ;
               endcase
            end
            link_ra = req_event_id;
            due_ra  = req_event_id;
            head_ra = (req_mode_t == MODE_NEXT) ? cur_bin_ff : req_bin;
            if (acc) begin
               id_in       = req_event_id;
               time_in     = req_event_time;
               bin_in      = req_bin;
               i_in        = '0;
               fall_in     = 1'b0;
               best_in     = '0;
               win_base_in = cur_win;
               res_id_in   = '0;
               res_time_in = '0;
               case (req_mode_t)
                  MODE_SCHED, MODE_CANCEL:
                     res_status_in = (req_event_id == '0) ? STS_BAD_ID : STS_OK;
                  MODE_NEXT:
                     res_status_in = (pend_cnt_ff == '0) ? STS_EMPTY : STS_OK;
                  default: res_status_in = STS_OK;
               endcase
            end
         end
         S_SCHED: begin
            if (link_rd_ff != NOT_PENDING) begin
               res_status_in = STS_ALREADY;
            end else if (time_ff < cur_time_ff) begin
               res_status_in = STS_PAST;
            end else begin
               due_we      = 1'b1;
               link_we     = 1'b1;
               link_wd     = {1'b0, head_rd_ff};
               head_we     = 1'b1;
               head_wd     = id_ff;
               pend_cnt_in = pend_cnt_ff + CNT_BITS'(1);
            end
         end
         S_CAN_LOOK: begin
            if (link_rd_ff == NOT_PENDING) begin
               res_status_in = STS_NOT_SCHED;
            end else begin
               idnext_in = link_rd_ff[ID_BITS-1:0];
               bin_in    = rd_bin;
               head_ra   = rd_bin;
               prev_in   = '0;
            end
         end
         S_CAN_HEAD, S_CAN_WALK: begin
            if (can_cur == '0) begin
               res_status_in = STS_NOT_SCHED;
            end else if (can_cur == id_ff) begin
               if (prev_ff == '0) begin
                  head_we = 1'b1;
                  head_wd = idnext_ff;
               end else begin
                  link_we = 1'b1;
                  link_wa = prev_ff;
                  link_wd = {1'b0, idnext_ff};
               end
            end else begin
               link_ra = can_cur;
               prev_in = can_cur;
            end
         end
         S_CAN_FIX: begin
            link_we       = 1'b1;
            pend_cnt_in   = pend_cnt_ff - CNT_BITS'(1);
            res_status_in = STS_OK;
         end
         S_NXT_HEAD, S_NXT_EVAL: begin
            if (state_ff == S_NXT_HEAD) begin
               link_ra = head_rd_ff;
               due_ra  = head_rd_ff;
               cur_in  = head_rd_ff;
               prev_in = '0;
            end else begin
               prev_in = cur_ff;
               link_ra = nx_ptr;
               due_ra  = nx_ptr;
               cur_in  = nx_ptr;
               if (upd) begin
                  best_in      = cur_ff;
                  best_t_in    = due_rd_ff;
                  best_prev_in = prev_ff;
                  best_bin_in  = bin_cur;
                  best_next_in = nx_ptr;
               end
            end
            if (bin_adv) begin
               if (last_bin) begin
                  if (fall_ff) begin
                     res_status_in = STS_EMPTY;
                  end else begin
                     fall_in = 1'b1;
                     i_in    = '0;
                     head_ra = '0;
                  end
               end else begin
                  i_in    = i_ff + BIN_BITS'(1);
                  head_ra = adv_addr;
               end
            end
         end
         S_NXT_FIX: begin
            if (best_prev_ff == '0) begin
               head_we = 1'b1;
               head_wa = best_bin_ff;
               head_wd = best_next_ff;
            end else begin
               link_we = 1'b1;
               link_wa = best_prev_ff;
               link_wd = {1'b0, best_next_ff};
            end
         end
         S_NXT_FREE: begin
            link_we     = 1'b1;
            link_wa     = best_ff;
            pend_cnt_in = pend_cnt_ff - CNT_BITS'(1);
            if (shamt < SHAMT_BITS'(TIME_BITS)) begin
               cyc_origin_in = cyc_origin_ff + (diff & ({TIME_BITS{1'b1}} << shamt));
            end
            cur_bin_in    = best_bin_ff;
            cur_time_in   = best_t_ff;
            res_id_in     = best_ff;
            res_time_in   = best_t_ff;
            res_status_in = STS_OK;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in     = 1'b1;
               rsp_next_id_in   = res_id_ff;
               rsp_next_time_in = res_time_ff;
               rsp_status_in    = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         fall_ff       <= 1'b0;
         best_ff       <= '0;
         pend_cnt_ff   <= '0;
         cyc_origin_ff <= START_RESET;
         cur_time_ff   <= START_RESET;
         cur_bin_ff    <= '0;
         start_time_ff <= START_RESET;
         bin_shift_ff  <= BIN_SHIFT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         fall_ff       <= fall_in;
         best_ff       <= best_in;
         pend_cnt_ff   <= pend_cnt_in;
         cyc_origin_ff <= cyc_origin_in;
         cur_time_ff   <= cur_time_in;
         cur_bin_ff    <= cur_bin_in;
         start_time_ff <= start_time_in;
         bin_shift_ff  <= bin_shift_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff            <= id_in;
      time_ff          <= time_in;
      bin_ff           <= bin_in;
      idnext_ff        <= idnext_in;
      prev_ff          <= prev_in;
      cur_ff           <= cur_in;
      i_ff             <= i_in;
      best_t_ff        <= best_t_in;
      best_prev_ff     <= best_prev_in;
      best_bin_ff      <= best_bin_in;
      best_next_ff     <= best_next_in;
      win_base_ff      <= win_base_in;
      res_id_ff        <= res_id_in;
      res_time_ff      <= res_time_in;
      res_status_ff    <= res_status_in;
      rsp_next_id_ff   <= rsp_next_id_in;
      rsp_next_time_ff <= rsp_next_time_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_id   = rsp_next_id_ff;
   assign rsp_next_time = rsp_next_time_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff <= CNT_BITS'(NUM_EVENTS - 1))
      else $error("pending count out of range");

   a_origin_le_now: assert property (@(posedge clock) disable iff (reset)
      cyc_origin_ff <= cur_time_ff)
      else $error("cycle origin ahead of current time");

   a_cur_bin: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> cur_bin_chk == cur_bin_ff)
      else $error("current bin does not match current time");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !due_we && !link_we && !head_we)
      else $error("memory write while idle");

   a_free_has_best: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NXT_FIX |=> best_ff != '0)
      else $error("next event released without a winner");
`endif

endmodule
